// ===== hw/rtl/staircase_dimmer_ramp_sequencer_unit_macros.svh =====
// Assertion macros for the staircase dimmer ramp sequencer checker.
// Include this file by its bare name; it needs no other file.
`ifndef STAIRCASE_DIMMER_RAMP_SEQUENCER_UNIT_MACROS_SVH
`define STAIRCASE_DIMMER_RAMP_SEQUENCER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SDRS_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sdrs assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SDRS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sdrs assertion failed");

`endif

// ===== hw/rtl/sdrs_pkg.sv =====
// Shared types, codes and helper functions of the dimmer ramp sequencer.
// No dependencies; every other RTL file but the macro header imports this package.
`default_nettype none

package sdrs_pkg;

    localparam int TABLE_SIZE = 256;
    localparam int POS_W      = 24;
    localparam int STEP_W     = POS_W + 1;
    localparam int CYC_W      = 16;
    localparam int LVL_W      = 8;
    localparam int PH_W       = 3;
    localparam int REQ_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int DIV_CNT_W  = $clog2(POS_W);

    localparam logic [LVL_W-1:0] LEVEL_MAX = LVL_W'(TABLE_SIZE - 1);

    // Phase codes.
    localparam logic [PH_W-1:0] PH_UP   = 3'd0;
    localparam logic [PH_W-1:0] PH_HOLD = 3'd1;
    localparam logic [PH_W-1:0] PH_DOWN = 3'd2;
    localparam logic [PH_W-1:0] PH_IDLE = 3'd3;
    localparam logic [PH_W-1:0] PH_PERM = 3'd4;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_EDGE    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_TRIGGER = 2'd1;
    localparam logic [REQ_W-1:0] REQ_POLL    = 2'd2;

    // Half-cycle step codes.
    localparam logic [1:0] HS_UPPER = 2'd0;
    localparam logic [1:0] HS_LOWER = 2'd1;
    localparam logic [1:0] HS_END   = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_START_POS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_UP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_RETRG = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_DOWN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CYC_UP     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CYC_HOLD   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CYC_DOWN   = 3'd6;

    typedef struct packed {
        logic capture;
        logic div_start;
        logic apply;
    } sdrs_cmd_t;

    typedef struct packed {
        logic [PH_W-1:0] phase;
        logic            div_done;
    } sdrs_stat_t;

    function automatic logic [LVL_W-1:0] level_of(input logic [POS_W-1:0] pos);
        logic [LVL_W-1:0] idx;
        idx = pos[POS_W-1 -: LVL_W];
        return (idx > LEVEL_MAX) ? LEVEL_MAX : idx;
    endfunction

    function automatic logic [CYC_W-1:0] at_least_one(input logic [CYC_W-1:0] c);
        return (c == '0) ? CYC_W'(1) : c;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/sdrs_div.sv =====
// Restoring serial divider, one quotient bit per cycle, for the retrigger
// cycle count. Depends on sdrs_pkg.
`default_nettype none

module sdrs_div
    import sdrs_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [POS_W-1:0] dividend,
    input  wire logic [POS_W-1:0] divisor,
    output logic                  done,
    output logic [CYC_W-1:0]      quotient
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [POS_W-1:0]     rem_reg, rem_next;
    logic [POS_W-1:0]     quo_reg, quo_next;
    logic [POS_W:0]       trial;

    // The quotient register first holds the dividend and shifts quotient
    // bits in from the right as dividend bits leave on the left.
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        trial     = {rem_reg, quo_reg[POS_W-1]} - {1'b0, divisor};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(POS_W - 1);
            rem_next  = '0;
            quo_next  = dividend;
        end else if (busy_reg) begin
            if (!trial[POS_W]) begin
                rem_next = trial[POS_W-1:0];
                quo_next = {quo_reg[POS_W-2:0], 1'b1};
            end else begin
                rem_next = {rem_reg[POS_W-2:0], quo_reg[POS_W-1]};
                quo_next = {quo_reg[POS_W-2:0], 1'b0};
            end
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    // A zero divisor yields an all-ones quotient, which saturates here too.
    assign done     = done_reg;
    assign quotient = (|quo_reg[POS_W-1:CYC_W]) ? '1 : quo_reg[CYC_W-1:0];

endmodule

`default_nettype wire

// ===== hw/rtl/sdrs_datapath.sv =====
// Datapath of the dimmer ramp sequencer: configuration registers, phase
// state, position arithmetic and the result register. Depends on sdrs_pkg, sdrs_div.
`default_nettype none

module sdrs_datapath
    import sdrs_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire sdrs_cmd_t            cmd,
    output sdrs_stat_t                stat,
    input  wire logic [REQ_W-1:0]     req_type,
    input  wire logic                 permanent_switch,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [POS_W-1:0]     cfg_wdata,
    output logic [PH_W-1:0]           out_phase,
    output logic                      out_load_timer,
    output logic [LVL_W-1:0]          out_fire_level,
    output logic                      out_gate_enable,
    output logic                      out_triac_forced_on
);

    logic [POS_W-1:0] start_pos_reg, step_up_reg, step_retrg_reg, step_down_reg;
    logic [CYC_W-1:0] cyc_up_reg, cyc_hold_reg, cyc_down_reg;

    logic [REQ_W-1:0]  req_reg;
    logic              sw_reg;

    logic [PH_W-1:0]   phase_reg, phase_next;
    logic [PH_W-1:0]   follow_reg, follow_next;
    logic [1:0]        hstep_reg, hstep_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [CYC_W-1:0]  cyc_reg, cyc_next;
    logic [LVL_W-1:0]  pend_reg, pend_next;
    logic              fire_reg, fire_next;

    logic              load;
    logic [LVL_W-1:0]  lvl;
    logic [STEP_W:0]   sum;
    logic [POS_W-1:0]  pos_sat;
    logic [CYC_W-1:0]  cyc_dec;
    logic [CYC_W-1:0]  skip;
    logic              div_done;

    sdrs_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (pos_reg),
        .divisor  (step_retrg_reg),
        .done     (div_done),
        .quotient (skip)
    );

    always_comb begin
        sum = {2'b00, pos_reg} + {step_reg[STEP_W-1], step_reg};
        if (sum[STEP_W]) begin
            pos_sat = '0;
        end else if (sum[POS_W]) begin
            pos_sat = '1;
        end else begin
            pos_sat = sum[POS_W-1:0];
        end
        cyc_dec = (cyc_reg == '0) ? '0 : cyc_reg - 1'b1;
    end

    always_comb begin
        phase_next  = phase_reg;
        follow_next = follow_reg;
        hstep_next  = hstep_reg;
        pos_next    = pos_reg;
        step_next   = step_reg;
        cyc_next    = cyc_reg;
        pend_next   = pend_reg;
        fire_next   = fire_reg;
        load        = 1'b0;
        lvl         = '0;
        case (req_reg)
            REQ_EDGE: begin
                if (fire_reg) begin
                    load = 1'b1;
                    lvl  = pend_reg;
                    case (hstep_reg)
                        HS_UPPER: begin
                            pos_next   = pos_sat;
                            pend_next  = level_of(pos_sat);
                            cyc_next   = cyc_dec;
                            hstep_next = (cyc_dec == '0) ? HS_END : HS_LOWER;
                        end
                        HS_END: begin
                            case (follow_reg)
                                PH_UP: begin
                                    pos_next    = start_pos_reg;
                                    cyc_next    = at_least_one(cyc_up_reg);
                                    step_next   = {1'b0, step_up_reg};
                                    hstep_next  = HS_UPPER;
                                    phase_next  = PH_UP;
                                    follow_next = PH_HOLD;
                                end
                                PH_HOLD: begin
                                    cyc_next    = at_least_one(cyc_hold_reg);
                                    step_next   = '0;
                                    hstep_next  = HS_UPPER;
                                    phase_next  = PH_HOLD;
                                    follow_next = PH_DOWN;
                                end
                                PH_DOWN: begin
                                    cyc_next    = at_least_one(cyc_down_reg);
                                    step_next   = -{1'b0, step_down_reg};
                                    hstep_next  = HS_UPPER;
                                    phase_next  = PH_DOWN;
                                    follow_next = PH_IDLE;
                                end
                                PH_IDLE: begin
                                    fire_next  = 1'b0;
                                    phase_next = PH_IDLE;
                                end
                                default: ;
                            endcase
                        end
                        // The lower half and the unused step code both return to the upper half.
                        default: hstep_next = HS_UPPER;
                    endcase
                end
            end
            REQ_TRIGGER: begin
                if (phase_reg == PH_IDLE) begin
                    pos_next    = start_pos_reg;
                    cyc_next    = at_least_one(cyc_up_reg);
                    step_next   = {1'b0, step_up_reg};
                    hstep_next  = HS_UPPER;
                    phase_next  = PH_UP;
                    follow_next = PH_HOLD;
                    pend_next   = level_of(start_pos_reg);
                    load        = 1'b1;
                    lvl         = level_of(start_pos_reg);
                    fire_next   = 1'b1;
                end else if (phase_reg == PH_HOLD) begin
                    cyc_next = at_least_one(cyc_hold_reg);
                end else if (phase_reg == PH_DOWN) begin
                    cyc_next    = (skip >= cyc_up_reg) ? CYC_W'(1) : cyc_up_reg - skip;
                    step_next   = {1'b0, step_retrg_reg};
                    pend_next   = level_of(pos_reg);
                    load        = 1'b1;
                    lvl         = level_of(pos_reg);
                    hstep_next  = HS_UPPER;
                    phase_next  = PH_UP;
                    follow_next = PH_HOLD;
                end
            end
            REQ_POLL: begin
                if (sw_reg) begin
                    fire_next   = 1'b0;
                    phase_next  = PH_PERM;
                    follow_next = PH_PERM;
                end else if (phase_reg == PH_PERM) begin
                    phase_next  = PH_IDLE;
                    follow_next = PH_IDLE;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_pos_reg  <= '0;
            step_up_reg    <= POS_W'(65536);
            step_retrg_reg <= POS_W'(65536);
            step_down_reg  <= POS_W'(65536);
            cyc_up_reg     <= CYC_W'(50);
            cyc_hold_reg   <= CYC_W'(500);
            cyc_down_reg   <= CYC_W'(50);
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_START_POS:  start_pos_reg  <= cfg_wdata;
                CFG_STEP_UP:    step_up_reg    <= cfg_wdata;
                CFG_STEP_RETRG: step_retrg_reg <= cfg_wdata;
                CFG_STEP_DOWN:  step_down_reg  <= cfg_wdata;
                CFG_CYC_UP:     cyc_up_reg     <= cfg_wdata[CYC_W-1:0];
                CFG_CYC_HOLD:   cyc_hold_reg   <= cfg_wdata[CYC_W-1:0];
                CFG_CYC_DOWN:   cyc_down_reg   <= cfg_wdata[CYC_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            follow_reg <= PH_IDLE;
            hstep_reg  <= HS_UPPER;
            pos_reg    <= '0;
            step_reg   <= '0;
            cyc_reg    <= '0;
            pend_reg   <= '0;
            fire_reg   <= 1'b0;
        end else if (cmd.apply) begin
            phase_reg  <= phase_next;
            follow_reg <= follow_next;
            hstep_reg  <= hstep_next;
            pos_reg    <= pos_next;
            step_reg   <= step_next;
            cyc_reg    <= cyc_next;
            pend_reg   <= pend_next;
            fire_reg   <= fire_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg <= req_type;
            sw_reg  <= permanent_switch;
        end
        if (cmd.apply) begin
            out_phase           <= phase_next;
            out_load_timer      <= load;
            out_fire_level      <= lvl;
            out_gate_enable     <= fire_next;
            out_triac_forced_on <= (phase_next == PH_PERM);
        end
    end

    assign stat.phase    = phase_reg;
    assign stat.div_done = div_done;

endmodule

`default_nettype wire

// ===== hw/rtl/sdrs_ctrl.sv =====
// Controller of the dimmer ramp sequencer: input and result handshakes and
// the sequence capture, divide (for a trigger during ramp down only), apply. Depends on sdrs_pkg.
`default_nettype none

module sdrs_ctrl
    import sdrs_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [REQ_W-1:0] s_req_type,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output sdrs_cmd_t             cmd,
    input  wire sdrs_stat_t       stat
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_DIV   = 2'd1;
    localparam logic [1:0] ST_APPLY = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || m_ready;

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (m_ready) begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                cmd.capture = s_valid;
                if (s_valid) begin
                    // Only a trigger during ramp down needs the quotient.
                    if (s_req_type == REQ_TRIGGER && stat.phase == PH_DOWN) begin
                        cmd.div_start = 1'b1;
                        state_next    = ST_DIV;
                    end else begin
                        state_next = ST_APPLY;
                    end
                end
            end
            ST_DIV: begin
                if (stat.div_done) begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY: begin
                if (out_free) begin
                    cmd.apply      = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = out_valid_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/staircase_dimmer_ramp_sequencer_unit.sv =====
// Top level of the staircase dimmer ramp sequencer: joins controller and datapath.
// Depends on sdrs_pkg, sdrs_ctrl, sdrs_datapath and sdrs_div.
//
// One event item goes in, one result item comes out. An ordinary item is
// captured in the idle state and applied in the apply state, which waits for a
// free output register; its result becomes valid in the same cycle as the input
// is ready again, and a new item is taken only once the last one is applied.
// A trigger during ramp down passes the divide state between capture and apply,
// in which the serial divider computes how many ramp-up cycles remain, and its
// result also becomes valid in the same cycle as the input is ready again.
// The result waits in an output register, so the block accepts the next item
// while a result is still pending; a new result is written only once the old
// one has been taken, and the input stays not ready until then. Configuration
// is written through cfg_we, cfg_index and cfg_wdata; the user must write it
// only while no item is in flight, which the block itself does not enforce.
`default_nettype none

module staircase_dimmer_ramp_sequencer_unit
    import sdrs_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [REQ_W-1:0]     s_req_type,
    input  wire logic                 s_permanent_switch,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [PH_W-1:0]           m_phase,
    output logic                      m_load_timer,
    output logic [LVL_W-1:0]          m_fire_level,
    output logic                      m_gate_enable,
    output logic                      m_triac_forced_on,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [POS_W-1:0]     cfg_wdata
);

    sdrs_cmd_t  cmd;
    sdrs_stat_t stat;

    sdrs_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req_type (s_req_type),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .cmd        (cmd),
        .stat       (stat)
    );

    sdrs_datapath u_dp (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cmd                 (cmd),
        .stat                (stat),
        .req_type            (s_req_type),
        .permanent_switch    (s_permanent_switch),
        .cfg_we              (cfg_we),
        .cfg_index           (cfg_index),
        .cfg_wdata           (cfg_wdata),
        .out_phase           (m_phase),
        .out_load_timer      (m_load_timer),
        .out_fire_level      (m_fire_level),
        .out_gate_enable     (m_gate_enable),
        .out_triac_forced_on (m_triac_forced_on)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/sdrs_checker.sv =====
// Port-level checker for the staircase dimmer ramp sequencer, bound to the top.
// Depends on sdrs_pkg and the assertion macro header.
`default_nettype none
`include "staircase_dimmer_ramp_sequencer_unit_macros.svh"

module sdrs_checker
    import sdrs_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_valid,
    input wire logic                 s_ready,
    input wire logic                 m_valid,
    input wire logic                 m_ready,
    input wire logic [PH_W-1:0]      m_phase,
    input wire logic                 m_load_timer,
    input wire logic [LVL_W-1:0]     m_fire_level,
    input wire logic                 m_gate_enable,
    input wire logic                 m_triac_forced_on
);

    // A stalled result keeps its phase, fire level and timer load.
    `SDRS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_phase) && $stable(m_fire_level) && $stable(m_load_timer))

    // Only one item is worked on at a time.
    `SDRS_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_valid && s_ready, !s_ready)

    // The triac is forced on exactly in permanent mode.
    `SDRS_ASSERT_SAME(a_forced_perm, aclk, aresetn, m_valid, m_triac_forced_on == (m_phase == PH_PERM))

    // Phase-angle firing is never on in permanent mode or idle.
    `SDRS_ASSERT_SAME(a_gate_off, aclk, aresetn, m_valid && (m_phase == PH_PERM || m_phase == PH_IDLE), !m_gate_enable)

    // No timer load means a zero level.
    `SDRS_ASSERT_SAME(a_level_zero, aclk, aresetn, m_valid && !m_load_timer, m_fire_level == '0)

endmodule

bind staircase_dimmer_ramp_sequencer_unit sdrs_checker u_sdrs_checker (.*);

`default_nettype wire
